// File: rtl/gbfs_pkg.sv
// ---------------------------------------------------------------------------
// gbfs_pkg: shared types and constants for the grid BFS step finder
// Step codes and the neighbor unit's request/response bundles.
// ---------------------------------------------------------------------------
package gbfs_pkg;

   localparam logic [2:0] STEP_NONE  = 3'd0;
   localparam logic [2:0] STEP_UP    = 3'd1;
   localparam logic [2:0] STEP_LEFT  = 3'd2;
   localparam logic [2:0] STEP_DOWN  = 3'd3;
   localparam logic [2:0] STEP_RIGHT = 3'd4;

   localparam logic [1:0] CSR_ACTIVE_ROWS    = 2'd0;
   localparam logic [1:0] CSR_ACTIVE_COLUMNS = 2'd1;
   localparam logic [1:0] CSR_TUNNEL_ROW     = 2'd2;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam int unsigned COORD_W = 6;
   localparam logic [7:0] FAR_DISTANCE = 8'hFF;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [2:0]         dir;
      logic [COORD_W:0]   rows;
      logic [COORD_W:0]   cols;
      logic               tunnel;
   } move_req_type;

   typedef struct packed {
      logic               ok;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } move_rsp_type;

endpackage

// File: rtl/gbfs_move.sv
// ---------------------------------------------------------------------------
// gbfs_move: neighbor step unit
// Computes the neighbor tile of one move on the active board, with the
// tunnel wrap; walkability is checked by the caller.
// ---------------------------------------------------------------------------
module gbfs_move (
   input  gbfs_pkg::move_req_type req,
   output gbfs_pkg::move_rsp_type rsp
);
   import gbfs_pkg::*;

   always_comb begin
      rsp.ok  = 1'b1;
      rsp.row = req.row;
      rsp.col = req.col;
      unique case (req.dir)
         STEP_UP: begin
            if (req.row == '0) rsp.ok = 1'b0;
            else rsp.row = req.row - 1'b1;
         end
         STEP_DOWN: begin
            if ({1'b0, req.row} + 1'b1 >= req.rows) rsp.ok = 1'b0;
            else rsp.row = req.row + 1'b1;
         end
         STEP_LEFT: begin
            if (req.col == '0) begin
               if (!req.tunnel) rsp.ok = 1'b0;
               else rsp.col = COORD_W'(req.cols - 1'b1);
            end else begin
               rsp.col = req.col - 1'b1;
            end
         end
         STEP_RIGHT: begin
            if ({1'b0, req.col} + 1'b1 >= req.cols) begin
               if (!req.tunnel || ({1'b0, req.col} + 1'b1 != req.cols)) rsp.ok = 1'b0;
               else rsp.col = '0;
            end else begin
               rsp.col = req.col + 1'b1;
            end
         end
         default: rsp.ok = 1'b0;
      endcase
   end
endmodule

// File: rtl/grid_bfs_first_step.sv
// ---------------------------------------------------------------------------
// grid_bfs_first_step: first step of a shortest grid path
// Row writes fill a walkable bitmap; queries clamp and snap the target,
// run a breadth-first search and return the first move.
// ---------------------------------------------------------------------------
// channel  dir  payload
// req_*    in   tuser: mode
//               tdata: map_row_index, map_row_bits, start_row, start_column,
//                      target_row, target_column
// rsp_*    out  tdata: first_step
// csr_*    in   index, data
// A row write goes straight to ST_DONE; a query with an off-board start
// answers STEP_NONE. Other queries clear the visited marks, snap a
// blocked target to the nearest open tile, then pop tiles (ST_POP,
// ST_POP_WAIT, ST_POP_CHECK) and try each move (ST_NEIGHBOR, ST_NB_WAIT).
// Reset restores the state and CSRs; the map is undefined until written.
// req_tready is low from acceptance until the result is taken.
// ---------------------------------------------------------------------------
module grid_bfs_first_step #(
   parameter int unsigned MAX_ROWS    = 32,
   parameter int unsigned MAX_COLUMNS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode
   input  logic        req_tuser,
   // map_row_index[4:0], map_row_bits[36:5], start_row[41:37],
   // start_column[46:42], target_row[53:47], target_column[60:54]
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // first_step[2:0]
   output logic [7:0]  rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_data
);
   import gbfs_pkg::*;

   localparam int unsigned RB     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int unsigned CB     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int unsigned TILES  = MAX_ROWS * MAX_COLUMNS;
   localparam int unsigned TB     = RB + CB;
   localparam int unsigned TSLOTS = 1 << TB;
   localparam int unsigned QB     = $clog2(TILES + 1);
   localparam logic [2:0]  SNAP_SCAN = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_SNAP, ST_SEED, ST_POP, ST_POP_WAIT, ST_POP_CHECK,
      ST_NEIGHBOR, ST_NB_WAIT, ST_DONE
   } state_type;

   state_type          state_ff;
   logic [5:0]         act_rows_ff, act_cols_ff;
   logic [4:0]         tunnel_ff;
   logic               rsp_valid_ff;
   logic [2:0]         step_ff;

   logic [MAX_COLUMNS-1:0] map_mem [MAX_ROWS];
   logic                   vis_mem [TSLOTS];
   logic [2:0]             dir_mem [TSLOTS];
   logic [TB-1:0]          que_mem [TILES];

   logic [COORD_W-1:0] sr_ff, sc_ff, gr_ff, gc_ff, cr_ff, cc_ff, br_ff, bc_ff;
   logic [COORD_W-1:0] nr_ff, nc_ff;
   logic [7:0]         best_ff;
   logic [QB-1:0]      head_ff, tail_ff;
   logic [2:0]         dir_ff, cdir_ff;
   logic [MAX_COLUMNS-1:0] row_rd_ff;
   logic               vis_rd_ff;
   logic [2:0]         dir_rd_ff;
   logic [TB-1:0]      que_rd_ff;

   logic [COORD_W:0] h, w;
   logic [6:0]       tr, tc;
   logic [COORD_W-1:0] gr_c, gc_c;
   move_req_type     mreq;
   move_rsp_type     mrsp;

   assign h = (act_rows_ff == '0) ? 7'd1 :
              ({1'b0, act_rows_ff} > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : {1'b0, act_rows_ff};
   assign w = (act_cols_ff == '0) ? 7'd1 :
              ({1'b0, act_cols_ff} > 7'(MAX_COLUMNS)) ? 7'(MAX_COLUMNS) :
              {1'b0, act_cols_ff};
   assign tr = req_tdata[53:47];
   assign tc = req_tdata[60:54];
   assign gr_c = tr[6] ? '0 : ({1'b0, tr} >= {1'b0, h}) ? COORD_W'(h - 1'b1) : COORD_W'(tr);
   assign gc_c = tc[6] ? '0 : ({1'b0, tc} >= {1'b0, w}) ? COORD_W'(w - 1'b1) : COORD_W'(tc);

   assign mreq.row    = cr_ff;
   assign mreq.col    = cc_ff;
   assign mreq.dir    = dir_ff;
   assign mreq.rows   = h;
   assign mreq.cols   = w;
   assign mreq.tunnel = ({1'b0, cr_ff} == {2'b0, tunnel_ff});

   gbfs_move u_move (.req(mreq), .rsp(mrsp));

   function automatic logic [TB-1:0] tidx(input logic [COORD_W-1:0] r,
                                           input logic [COORD_W-1:0] c);
      return {r[RB-1:0], c[CB-1:0]};
   endfunction

   // snap scan uses cr/cc as a row-major cursor
   logic [7:0] snap_dist;
   logic       snap_open;
   assign snap_dist = 8'((cr_ff > gr_ff ? cr_ff - gr_ff : gr_ff - cr_ff) +
                         (cc_ff > gc_ff ? cc_ff - gc_ff : gc_ff - cc_ff));
   assign snap_open = row_rd_ff[cc_ff[CB-1:0]];

   logic last_col, last_row;
   assign last_col = ({1'b0, cc_ff} + 1'b1 == w);
   assign last_row = ({1'b0, cr_ff} + 1'b1 == h);

   logic [TB-1:0] nidx;
   assign nidx = tidx(nr_ff, nc_ff);

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, step_ff};

   logic [TB-1:0] clr_idx;
   assign clr_idx = tidx(cr_ff, cc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         act_rows_ff  <= 6'd31;
         act_cols_ff  <= 6'd28;
         tunnel_ff    <= 5'd14;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_ACTIVE_ROWS:    act_rows_ff <= csr_data;
               CSR_ACTIVE_COLUMNS: act_cols_ff <= csr_data;
               CSR_TUNNEL_ROW:     tunnel_ff   <= csr_data[4:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (req_tvalid && req_tready) begin
               step_ff <= STEP_NONE;
               dir_ff <= STEP_NONE;
               sr_ff <= {1'b0, req_tdata[41:37]};
               sc_ff <= {1'b0, req_tdata[46:42]};
               gr_ff <= gr_c;
               gc_ff <= gc_c;
               cr_ff <= '0;
               cc_ff <= '0;
               if (req_tuser == MODE_WRITE) begin
                  if ({2'b0, req_tdata[4:0]} < 7'(MAX_ROWS))
                     map_mem[RB'(req_tdata[4:0])] <= MAX_COLUMNS'(req_tdata[36:5]);
                  state_ff <= ST_DONE;
               end else if ({2'b0, req_tdata[41:37]} >= h ||
                            {2'b0, req_tdata[46:42]} >= w) begin
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_CLEAR;
               end
            end
            ST_CLEAR: begin
               vis_mem[clr_idx] <= 1'b0;
               if (last_col) begin
                  cc_ff <= '0;
                  if (last_row) begin
                     cr_ff <= '0;
                     best_ff <= FAR_DISTANCE;
                     br_ff <= gr_ff;
                     bc_ff <= gc_ff;
                     row_rd_ff <= map_mem[gr_ff[RB-1:0]];
                     state_ff <= ST_SNAP;
                  end else cr_ff <= cr_ff + 1'b1;
               end else cc_ff <= cc_ff + 1'b1;
            end
            ST_SNAP: begin
               // first pass checks goal tile; afterwards row_rd holds row cr
               if (best_ff == FAR_DISTANCE && cr_ff == '0 && cc_ff == '0 &&
                   row_rd_ff[gc_ff[CB-1:0]] && br_ff == gr_ff && dir_ff != SNAP_SCAN) begin
                  state_ff <= ST_SEED;
               end else if (dir_ff != SNAP_SCAN) begin
                  dir_ff <= SNAP_SCAN;
                  row_rd_ff <= map_mem[0];
               end else begin
                  if (snap_open && snap_dist < best_ff) begin
                     best_ff <= snap_dist;
                     br_ff <= cr_ff;
                     bc_ff <= cc_ff;
                  end
                  if (last_col) begin
                     cc_ff <= '0;
                     if (last_row) state_ff <= ST_SEED;
                     else begin
                        cr_ff <= cr_ff + 1'b1;
                        row_rd_ff <= map_mem[RB'(cr_ff + 1'b1)];
                     end
                  end else cc_ff <= cc_ff + 1'b1;
               end
            end
            ST_SEED: begin
               if (dir_ff == SNAP_SCAN) begin
                  gr_ff <= br_ff;
                  gc_ff <= bc_ff;
               end
               dir_ff <= STEP_NONE;
               vis_mem[tidx(sr_ff, sc_ff)] <= 1'b1;
               dir_mem[tidx(sr_ff, sc_ff)] <= STEP_NONE;
               que_mem[0] <= tidx(sr_ff, sc_ff);
               head_ff <= '0;
               tail_ff <= QB'(1);
               state_ff <= ST_POP;
            end
            ST_POP: begin
               if (head_ff >= tail_ff || head_ff >= QB'(TILES)) state_ff <= ST_DONE;
               else begin
                  que_rd_ff <= que_mem[head_ff[TB-1:0]];
                  head_ff <= head_ff + 1'b1;
                  state_ff <= ST_POP_WAIT;
               end
            end
            ST_POP_WAIT: begin
               cr_ff <= COORD_W'(que_rd_ff[TB-1:CB]);
               cc_ff <= COORD_W'(que_rd_ff[CB-1:0]);
               dir_rd_ff <= dir_mem[que_rd_ff];
               state_ff <= ST_POP_CHECK;
            end
            ST_POP_CHECK: begin
               cdir_ff <= dir_rd_ff;
               if (cr_ff == gr_ff && cc_ff == gc_ff) begin
                  step_ff <= dir_rd_ff;
                  state_ff <= ST_DONE;
               end else begin
                  dir_ff <= STEP_UP;
                  state_ff <= ST_NEIGHBOR;
               end
            end
            ST_NEIGHBOR: begin
               nr_ff <= mrsp.row;
               nc_ff <= mrsp.col;
               row_rd_ff <= map_mem[mrsp.row[RB-1:0]];
               vis_rd_ff <= vis_mem[tidx(mrsp.row, mrsp.col)];
               if (mrsp.ok) state_ff <= ST_NB_WAIT;
               else if (dir_ff == STEP_RIGHT) state_ff <= ST_POP;
               else dir_ff <= dir_ff + 1'b1;
            end
            ST_NB_WAIT: begin
               if (row_rd_ff[nc_ff[CB-1:0]] && !vis_rd_ff && tail_ff < QB'(TILES)) begin
                  vis_mem[nidx] <= 1'b1;
                  dir_mem[nidx] <= (cr_ff == sr_ff && cc_ff == sc_ff) ? dir_ff : cdir_ff;
                  que_mem[tail_ff[TB-1:0]] <= nidx;
                  tail_ff <= tail_ff + 1'b1;
               end
               if (dir_ff == STEP_RIGHT) state_ff <= ST_POP;
               else begin
                  dir_ff <= dir_ff + 1'b1;
                  state_ff <= ST_NEIGHBOR;
               end
            end
            ST_DONE: begin
               rsp_valid_ff <= 1'b1;
               dir_ff <= STEP_NONE;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready) else $error("ready while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("response dropped");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (step_ff <= STEP_RIGHT)) else $error("bad step code");

endmodule

// File: verif/tb_grid_bfs_first_step.sv
// ---------------------------------------------------------------------------
// tb_grid_bfs_first_step: self-checking bench for the grid BFS step finder
// Loads walkable maps, sweeps board sizes and tunnel rows, and runs queries.
// Each query result is checked against a breadth-first search in the bench.
// ---------------------------------------------------------------------------
module tb_grid_bfs_first_step;
   import gbfs_pkg::*;

   localparam int GRID_SIDE = 32;
   localparam int TILES = GRID_SIDE * GRID_SIDE;
   localparam int CYCLE_LIMIT = 10000000;

   typedef struct {
      logic        mode;
      logic [4:0]  row_idx;
      logic [31:0] row_bits;
      logic [4:0]  start_r;
      logic [4:0]  start_c;
      logic [6:0]  tgt_r;
      logic [6:0]  tgt_c;
   } bfs_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // mode
   logic        req_tuser = 1'b0;
   // map_row_index, map_row_bits, start_row, start_column, target_row,
   // target_column
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // first_step
   logic [7:0]  rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [5:0]  csr_data = '0;

   bfs_item_type pending_items[$];
   logic [2:0]  expected_steps[$];
   bfs_item_type cur_item;
   logic [31:0] walk_map[GRID_SIDE];
   logic [31:0] plan_map[GRID_SIDE];
   logic [5:0]  rows_cfg = 6'd31;
   logic [5:0]  cols_cfg = 6'd28;
   logic [4:0]  tunnel_cfg = 5'd14;
   int          errors = 0;
   int          cycles = 0;
   int          results_taken = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          stall_left = 0;
   bit          long_hold_done = 0;

   grid_bfs_first_step i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic int board_dim(input logic [5:0] val);
      if (val == 0) return 1;
      if (val > GRID_SIDE) return GRID_SIDE;
      return val;
   endfunction

   function automatic bit tile_open(input int r, input int c);
      if (r < 0 || c < 0 || r >= GRID_SIDE || c >= GRID_SIDE) return 0;
      return walk_map[r][c];
   endfunction

   function automatic int clamp_coord(input logic [6:0] v, input int lim);
      int s;
      s = $signed(v);
      if (s < 0) return 0;
      if (s >= lim) return lim - 1;
      return s;
   endfunction

   function automatic bit step_to(input int r, input int c, input logic [2:0] dir,
                                  input int h, input int w,
                                  output int nr, output int nc);
      bit tun;
      tun = (r == tunnel_cfg);
      nr = r;
      nc = c;
      case (dir)
         STEP_UP: begin
            if (r == 0) return 0;
            nr = r - 1;
         end
         STEP_DOWN: begin
            if (r + 1 >= h) return 0;
            nr = r + 1;
         end
         STEP_LEFT: begin
            if (c == 0) begin
               if (!tun) return 0;
               nc = w - 1;
            end else begin
               nc = c - 1;
            end
         end
         STEP_RIGHT: begin
            if (c + 1 >= w) begin
               if (!tun || c + 1 != w) return 0;
               nc = 0;
            end else begin
               nc = c + 1;
            end
         end
         default: return 0;
      endcase
      return tile_open(nr, nc);
   endfunction

   function automatic logic [2:0] first_step_of(input bfs_item_type it);
      int h, w, sr, sc, gr, gc, best, br, bc, d, head, tail, idx, r, c, nr, nc, nidx;
      bit seen[TILES];
      logic [2:0] first_dir[TILES];
      int frontier[TILES];
      h = board_dim(rows_cfg);
      w = board_dim(cols_cfg);
      sr = it.start_r;
      sc = it.start_c;
      if (sr >= h || sc >= w) return STEP_NONE;
      gr = clamp_coord(it.tgt_r, h);
      gc = clamp_coord(it.tgt_c, w);
      if (!tile_open(gr, gc)) begin
         best = 'hFFFF;
         br = gr;
         bc = gc;
         for (int rr = 0; rr < h; rr++) begin
            for (int cc = 0; cc < w; cc++) begin
               if (tile_open(rr, cc)) begin
                  d = (rr > gr ? rr - gr : gr - rr) + (cc > gc ? cc - gc : gc - cc);
                  if (d < best) begin
                     best = d;
                     br = rr;
                     bc = cc;
                  end
               end
            end
         end
         gr = br;
         gc = bc;
      end
      foreach (seen[i]) seen[i] = 0;
      seen[sr * GRID_SIDE + sc] = 1;
      first_dir[sr * GRID_SIDE + sc] = STEP_NONE;
      frontier[0] = sr * GRID_SIDE + sc;
      head = 0;
      tail = 1;
      while (head < tail) begin
         idx = frontier[head];
         head++;
         r = idx / GRID_SIDE;
         c = idx % GRID_SIDE;
         if (r == gr && c == gc) return first_dir[idx];
         for (int k = STEP_UP; k <= STEP_RIGHT; k++) begin
            if (step_to(r, c, 3'(k), h, w, nr, nc)) begin
               nidx = nr * GRID_SIDE + nc;
               if (!seen[nidx]) begin
                  seen[nidx] = 1;
                  first_dir[nidx] = (r == sr && c == sc) ? 3'(k) : first_dir[idx];
                  frontier[tail] = nidx;
                  tail++;
               end
            end
         end
      end
      return STEP_NONE;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("mismatch: %s got %0d expected %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // cycle counter and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // sender: bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (cur_item.mode == MODE_WRITE) begin
               walk_map[cur_item.row_idx] = cur_item.row_bits;
               expected_steps.push_back(STEP_NONE);
            end else begin
               expected_steps.push_back(first_step_of(cur_item));
            end
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               cur_item = pending_items.pop_front();
               req_tuser <= cur_item.mode;
               req_tdata <= {3'b000, cur_item.tgt_c, cur_item.tgt_r, cur_item.start_c,
                             cur_item.start_r, cur_item.row_bits, cur_item.row_idx};
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 6);
                  gap_left = $urandom_range(0, 5);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: short random stalls, one long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!long_hold_done && results_taken == 30) begin
         long_hold_done = 1;
         stall_left = 600;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_taken++;
         if (expected_steps.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_tdata, 8'd0);
         end else if (rsp_tdata !== {5'd0, expected_steps[0]}) begin
            report_mismatch("first_step", rsp_tdata, {5'd0, expected_steps.pop_front()});
         end else begin
            void'(expected_steps.pop_front());
         end
      end
   end

   task automatic write_csr(input logic [1:0] index, input logic [5:0] data);
      @(posedge clock);
      csr_index <= index;
      csr_data <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (index)
         CSR_ACTIVE_ROWS: rows_cfg = data;
         CSR_ACTIVE_COLUMNS: cols_cfg = data;
         CSR_TUNNEL_ROW: tunnel_cfg = data[4:0];
         default: ;
      endcase
   endtask

   task automatic set_board(input int r, input int c, input int t);
      write_csr(CSR_ACTIVE_ROWS, 6'(r));
      write_csr(CSR_ACTIVE_COLUMNS, 6'(c));
      write_csr(CSR_TUNNEL_ROW, 6'(t));
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_steps.size() != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic add_write(input int row, input logic [31:0] bits);
      bfs_item_type it;
      it.mode = MODE_WRITE;
      it.row_idx = 5'(row);
      it.row_bits = bits;
      it.start_r = 5'($urandom);
      it.start_c = 5'($urandom);
      it.tgt_r = 7'($urandom);
      it.tgt_c = 7'($urandom);
      plan_map[row] = bits;
      pending_items.push_back(it);
   endtask

   task automatic add_query(input int sr, input int sc, input int tr, input int tc);
      bfs_item_type it;
      it.mode = MODE_QUERY;
      it.row_idx = 5'($urandom);
      it.row_bits = $urandom;
      it.start_r = 5'(sr);
      it.start_c = 5'(sc);
      it.tgt_r = 7'(tr);
      it.tgt_c = 7'(tc);
      pending_items.push_back(it);
   endtask

   task automatic run_random(input int count);
      int h, w, sr, sc;
      h = board_dim(rows_cfg);
      w = board_dim(cols_cfg);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            add_write(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                  : $urandom_range(0, h - 1),
                      ($urandom_range(0, 3) == 0) ? $urandom : ($urandom | $urandom));
         end else if ($urandom_range(0, 4) == 0) begin
            add_query($urandom_range(0, 31), $urandom_range(0, 31),
                      $urandom_range(0, 127), $urandom_range(0, 127));
         end else begin
            sr = $urandom_range(0, h - 1);
            sc = $urandom_range(0, w - 1);
            for (int k = 0; k < 8 && !plan_map[sr][sc]; k++) begin
               sr = $urandom_range(0, h - 1);
               sc = $urandom_range(0, w - 1);
            end
            add_query(sr, sc, $urandom_range(0, h - 1), $urandom_range(0, w - 1));
         end
      end
      wait_idle();
   endtask

   int cfg_rows[9] = '{32, 63, 0, 8, 5, 1, 32, 12, 2};
   int cfg_cols[9] = '{32, 63, 0, 8, 12, 32, 1, 7, 2};
   int cfg_tun[9]  = '{14, 31, 0, 3, 31, 0, 5, 11, 1};

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int r = 0; r < GRID_SIDE; r++) add_write(r, $urandom | $urandom);
      add_write(31, 32'hFFFF_FFFF);
      // default board: start off board, far targets, snapped target
      add_query(31, 3, 5, 5);
      add_query(3, 31, 5, 5);
      add_query(2, 2, -64, 63);
      add_query(20, 20, 63, -64);
      wait_idle();

      set_board(4, 4, 1);
      add_write(0, 32'hFFFF_FFFF);
      add_write(1, 32'h0000_0009);
      add_write(2, 32'h0000_0000);
      add_write(3, 32'h0000_0006);
      add_query(1, 0, 1, 3);
      add_query(1, 3, 1, 0);
      add_query(3, 1, 0, 0);
      add_query(2, 0, 0, 0);
      add_query(0, 0, 2, 2);
      add_query(0, 2, 0, 2);
      add_query(0, 0, -1, 40);
      add_query(1, 3, 0, 0);
      add_query(0, 3, 3, 0);
      wait_idle();

      for (int p = 0; p < 9; p++) begin
         set_board(cfg_rows[p], cfg_cols[p], cfg_tun[p]);
         for (int r = 0; r < board_dim(6'(cfg_rows[p])); r++)
            if ($urandom_range(0, 5) == 0) add_write(r, $urandom | $urandom | $urandom);
         run_random((board_dim(6'(cfg_rows[p])) * board_dim(6'(cfg_cols[p])) > 256) ? 4 : 5);
      end

      if (expected_steps.size() != 0) report_mismatch("leftover expectation", 8'd0, 8'd0);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
